// File: src/edge_graph_dfs_reachability_unit_assert.svh
// assertion macros for the edge graph reachability unit
`ifndef EDGE_GRAPH_DFS_REACHABILITY_UNIT_ASSERT_SVH
`define EDGE_GRAPH_DFS_REACHABILITY_UNIT_ASSERT_SVH
// clocked assertion, off while reset is held
`define EGDR_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// clocked assertion that also holds during reset
`define EGDR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

// File: src/egdr_pkg.sv
// shared types for the edge graph reachability unit
`default_nettype none
package egdr_pkg;
  localparam int EDGES = 6;

  typedef struct packed {
    logic [7:0] tile;
    logic [2:0] edg;
  } node_t;

  typedef struct packed {
    logic       has_link;
    logic [7:0] tile;
    logic [2:0] edg;
  } link_t;

  typedef struct packed {
    logic clr_step;
    logic load_wr;
    logic srch_start;
    logic pop_rd;
    logic node_cap;
    logic self_cap;
    logic cand_rd;
    logic c1_rd;
    logic push;
    logic next_cand;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic sp_zero;
    logic sp_full;
    logic node_end;
    logic node_rng;
    logic cand_end;
    logic cand_rng;
    logic c1_ok;
    logic c2_ok;
    logic i_last;
  } dp_stat_t;
endpackage
`default_nettype wire

// File: src/egdr_if.sv
// request and result channel interfaces
`default_nettype none
interface egdr_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] tile;
  logic [2:0] edge_req;
  logic       has_link;
  logic [7:0] link_tile;
  logic [2:0] link_edge;
  logic [7:0] end_tile;
  logic [2:0] end_edge;
  modport source (output valid, cmd, tile, edge_req, has_link, link_tile, link_edge,
                  end_tile, end_edge, input ready);
  modport sink (input valid, cmd, tile, edge_req, has_link, link_tile, link_edge,
                end_tile, end_edge, output ready);
endinterface

interface egdr_out_if;
  logic valid;
  logic ready;
  logic found;
  logic overflow;
  modport source (output valid, found, overflow, input ready);
  modport sink (input valid, found, overflow, output ready);
endinterface
`default_nettype wire

// File: src/egdr_dp.sv
// datapath: link table, visited marks, node stack and compare logic
`default_nettype none
module egdr_dp #(
  parameter int TILE_COUNT  = 256,
  parameter int STACK_DEPTH = 1024
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  egdr_pkg::dp_cmd_t    cmd,
  output egdr_pkg::dp_stat_t   stat,
  input  wire [7:0]            in_tile,
  input  wire [2:0]            in_edge_req,
  input  wire                  in_has_link,
  input  wire [7:0]            in_link_tile,
  input  wire [2:0]            in_link_edge,
  input  wire [7:0]            in_end_tile,
  input  wire [2:0]            in_end_edge
);
  localparam int NENT = TILE_COUNT * egdr_pkg::EDGES;
  localparam int IW   = $clog2(NENT);
  localparam int AW   = $clog2(STACK_DEPTH);
  localparam int SPW  = $clog2(STACK_DEPTH + 1);

  function automatic logic [IW-1:0] idx_of(input logic [7:0] t, input logic [2:0] e);
    logic [15:0] p;
    p = ({8'd0, t} << 2) + ({8'd0, t} << 1) + {13'd0, e};
    return p[IW-1:0];
  endfunction

  function automatic logic in_rng(input logic [7:0] t, input logic [2:0] e);
    return (32'(t) < TILE_COUNT) && (e < 3'(egdr_pkg::EDGES));
  endfunction

  egdr_pkg::link_t link_mem [NENT];
  logic            vis_mem  [NENT];
  egdr_pkg::node_t stk_mem  [STACK_DEPTH];

  egdr_pkg::link_t link_q;
  logic            vis_q;
  egdr_pkg::node_t stk_q;

  logic [7:0]     ht_r, nt_r, end_t_r;
  logic [2:0]     ne_r, end_e_r, i_r;
  logic [SPW-1:0] sp_r;
  logic [IW-1:0]  clr_r;

  logic [7:0]    ct;
  logic [2:0]    ce;
  logic [IW-1:0] cand_idx;
  logic [SPW-1:0] sp_m1;

  assign ct       = (i_r < 3'(egdr_pkg::EDGES)) ? ht_r : nt_r;
  assign ce       = (i_r < 3'(egdr_pkg::EDGES)) ? i_r : ne_r;
  assign cand_idx = idx_of(ct, ce);
  assign sp_m1    = sp_r - SPW'(1);

  // link table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.load_wr && in_rng(in_tile, in_edge_req)) begin
      link_mem[idx_of(in_tile, in_edge_req)] <= '{in_has_link, in_link_tile, in_link_edge};
    end
    if (cmd.node_cap) begin
      link_q <= link_mem[idx_of(stk_q.tile, stk_q.edg)];
    end else if (cmd.cand_rd) begin
      link_q <= link_mem[cand_idx];
    end else if (cmd.c1_rd) begin
      link_q <= link_mem[idx_of(link_q.tile, link_q.edg)];
    end
  end

  // visited marks
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      vis_mem[clr_r] <= 1'b0;
    end else if (cmd.load_wr && in_rng(in_tile, in_edge_req)) begin
      vis_mem[idx_of(in_tile, in_edge_req)] <= 1'b0;
    end else if (cmd.node_cap) begin
      vis_mem[idx_of(stk_q.tile, stk_q.edg)] <= 1'b1;
    end
    if (cmd.cand_rd) begin
      vis_q <= vis_mem[cand_idx];
    end
  end

  // node stack
  always_ff @(posedge clk) begin
    if (cmd.srch_start) begin
      stk_mem[AW'(0)] <= '{in_tile, in_edge_req};
    end else if (cmd.push) begin
      stk_mem[sp_r[AW-1:0]] <= '{ct, ce};
    end
    if (cmd.pop_rd) begin
      stk_q <= stk_mem[sp_m1[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r  <= '0;
      clr_r <= '0;
    end else begin
      if (cmd.clr_step) clr_r <= clr_r + IW'(1);
      if (cmd.srch_start) sp_r <= SPW'(1);
      else if (cmd.pop_rd) sp_r <= sp_m1;
      else if (cmd.push) sp_r <= sp_r + SPW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.srch_start) begin
      end_t_r <= in_end_tile;
      end_e_r <= in_end_edge;
    end
    if (cmd.node_cap) begin
      ht_r <= stk_q.tile;
      i_r  <= 3'd0;
    end else if (cmd.next_cand) begin
      i_r <= i_r + 3'd1;
    end
    if (cmd.self_cap) begin
      nt_r <= link_q.tile;
      ne_r <= link_q.edg;
    end
  end

  always_comb begin
    stat.clr_last = (clr_r == IW'(NENT - 1));
    stat.sp_zero  = (sp_r == '0);
    stat.sp_full  = (sp_r == SPW'(STACK_DEPTH));
    stat.node_end = (stk_q.tile == end_t_r) && (stk_q.edg == end_e_r);
    stat.node_rng = in_rng(stk_q.tile, stk_q.edg);
    stat.cand_end = (ct == end_t_r) && (ce == end_e_r);
    stat.cand_rng = in_rng(ct, ce);
    stat.c1_ok    = link_q.has_link && !vis_q && in_rng(link_q.tile, link_q.edg);
    stat.c2_ok    = (link_q.tile == ct) && (link_q.edg == ce);
    stat.i_last   = (i_r == 3'(egdr_pkg::EDGES));
  end
endmodule
`default_nettype wire

// File: src/egdr_ctrl.sv
// controller: search sequencer and result register
`default_nettype none
module egdr_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire                 in_cmd,
  output logic                out_valid,
  input  wire                 out_ready,
  output logic                out_found,
  output logic                out_overflow,
  output egdr_pkg::dp_cmd_t   cmd,
  input  egdr_pkg::dp_stat_t  stat
);
  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_POP   = 4'd2;
  localparam logic [3:0] S_POPW  = 4'd3;
  localparam logic [3:0] S_SELF  = 4'd4;
  localparam logic [3:0] S_CAND  = 4'd5;
  localparam logic [3:0] S_C1    = 4'd6;
  localparam logic [3:0] S_C2    = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic       found_r, found_nxt, ovf_r, ovf_nxt;
  logic       ov_r, ov_nxt, of_r, of_nxt, oo_r, oo_nxt;
  logic       try_push;

  assign in_ready     = (state_r == S_IDLE);
  assign out_valid    = ov_r;
  assign out_found    = of_r;
  assign out_overflow = oo_r;

  always_comb begin
    state_nxt = state_r;
    found_nxt = found_r;
    ovf_nxt   = ovf_r;
    ov_nxt    = ov_r && !out_ready;
    of_nxt    = of_r;
    oo_nxt    = oo_r;
    cmd       = '0;
    try_push  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          found_nxt = 1'b0;
          ovf_nxt   = 1'b0;
          if (!in_cmd) begin
            cmd.load_wr = 1'b1;
            state_nxt   = S_DONE;
          end else begin
            cmd.srch_start = 1'b1;
            state_nxt      = S_POP;
          end
        end
      end
      S_POP: begin
        if (stat.sp_zero) begin
          state_nxt = S_DONE;
        end else begin
          cmd.pop_rd = 1'b1;
          state_nxt  = S_POPW;
        end
      end
      S_POPW: begin
        if (stat.node_end) begin
          found_nxt = 1'b1;
          state_nxt = S_DONE;
        end else if (!stat.node_rng) begin
          state_nxt = S_POP;
        end else begin
          cmd.node_cap = 1'b1;
          state_nxt    = S_SELF;
        end
      end
      S_SELF: begin
        cmd.self_cap = 1'b1;
        state_nxt    = S_CAND;
      end
      S_CAND: begin
        if (stat.cand_end) begin
          try_push = 1'b1;
        end else if (!stat.cand_rng) begin
          state_nxt = stat.i_last ? S_POP : S_CAND;
          cmd.next_cand = !stat.i_last;
        end else begin
          cmd.cand_rd = 1'b1;
          state_nxt   = S_C1;
        end
      end
      S_C1: begin
        if (stat.c1_ok) begin
          cmd.c1_rd = 1'b1;
          state_nxt = S_C2;
        end else begin
          state_nxt     = stat.i_last ? S_POP : S_CAND;
          cmd.next_cand = !stat.i_last;
        end
      end
      S_C2: begin
        if (stat.c2_ok) begin
          try_push = 1'b1;
        end else begin
          state_nxt     = stat.i_last ? S_POP : S_CAND;
          cmd.next_cand = !stat.i_last;
        end
      end
      S_DONE: begin
        if (!ov_r || out_ready) begin
          ov_nxt    = 1'b1;
          of_nxt    = found_r;
          oo_nxt    = ovf_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (try_push) begin
      if (stat.sp_full) begin
        ovf_nxt   = 1'b1;
        state_nxt = S_DONE;
      end else begin
        cmd.push      = 1'b1;
        state_nxt     = stat.i_last ? S_POP : S_CAND;
        cmd.next_cand = !stat.i_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    found_r <= found_nxt;
    ovf_r   <= ovf_nxt;
    of_r    <= of_nxt;
    oo_r    <= oo_nxt;
  end
endmodule
`default_nettype wire

// File: src/edge_graph_dfs_reachability_unit.sv
// edge graph reachability unit: top level
// load request: entry written on acceptance, result registered from the done state
// search request: pop, pop-wait and self states per node; candidate and up to two check
// states per candidate edge, set by the single link table read port; one request at a time
// reset: a clearing pass sweeps all TILE_COUNT*6 visited marks, no request taken
`default_nettype none
module edge_graph_dfs_reachability_unit #(
  parameter int TILE_COUNT  = 256,
  parameter int STACK_DEPTH = 1024
) (
  input wire          clk,
  input wire          rst_n,
  egdr_in_if.sink     in_ch,
  egdr_out_if.source  out_ch
);
  egdr_pkg::dp_cmd_t  cmd;
  egdr_pkg::dp_stat_t stat;

  egdr_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_cmd       (in_ch.cmd),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_found    (out_ch.found),
    .out_overflow (out_ch.overflow),
    .cmd          (cmd),
    .stat         (stat)
  );

  egdr_dp #(
    .TILE_COUNT  (TILE_COUNT),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_tile      (in_ch.tile),
    .in_edge_req  (in_ch.edge_req),
    .in_has_link  (in_ch.has_link),
    .in_link_tile (in_ch.link_tile),
    .in_link_edge (in_ch.link_edge),
    .in_end_tile  (in_ch.end_tile),
    .in_end_edge  (in_ch.end_edge)
  );
endmodule
`default_nettype wire

// File: src/egdr_checker.sv
// port checker for the edge graph reachability unit
`default_nettype none
`include "edge_graph_dfs_reachability_unit_assert.svh"
module egdr_checker (
  input wire clk,
  input wire rst_n,
  input wire in_ready,
  input wire out_valid,
  input wire out_ready,
  input wire out_found,
  input wire out_overflow
);
  `EGDR_ASSERT_ALWAYS(a_clear_after_reset, clk, !rst_n |=> !in_ready, "request taken during clear")
  `EGDR_ASSERT(a_flags_exclusive, clk, rst_n, out_valid |-> !(out_found && out_overflow), "found with overflow")
  `EGDR_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "result dropped")
  `EGDR_ASSERT(a_out_stable, clk, rst_n, out_valid && !out_ready |=> $stable(out_found) && $stable(out_overflow), "result changed")
endmodule

bind edge_graph_dfs_reachability_unit egdr_checker u_egdr_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_found    (out_ch.found),
  .out_overflow (out_ch.overflow)
);
`default_nettype wire

// File: tb/egdr_tb_pkg.sv
// testbench package: request layout for the edge graph reachability unit
package egdr_tb_pkg;
  typedef enum logic {CMD_LOAD = 1'b0, CMD_SEARCH = 1'b1} cmd_e;

  typedef struct packed {
    logic       cmd;
    logic [7:0] tile;
    logic [2:0] edge_req;
    logic       has_link;
    logic [7:0] link_tile;
    logic [2:0] link_edge;
    logic [7:0] end_tile;
    logic [2:0] end_edge;
  } request_t;

  typedef struct packed {
    logic found;
    logic overflow;
  } verdict_t;
endpackage

// File: tb/edge_graph_dfs_reachability_unit_test.sv
// testbench top: random loads and searches checked against a graph walk model
module edge_graph_dfs_reachability_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import egdr_tb_pkg::*;

  localparam int TILES = 256;
  localparam int NEDGE = 6;
  localparam int ENTRIES = TILES * NEDGE;
  localparam int STACK_LIM = 1024;
  localparam int USED_TILES = 6;
  localparam longint LIMIT = 64'd20000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  egdr_in_if in_ch ();
  egdr_out_if out_ch ();

  edge_graph_dfs_reachability_unit dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic       lk_flag [ENTRIES];
  logic [7:0] lk_tile [ENTRIES];
  logic [2:0] lk_edge [ENTRIES];
  logic       lk_written [ENTRIES];
  logic       seen [ENTRIES];
  int         goal_t, goal_e;

  request_t pending_q[$];
  verdict_t verdict_q[$];
  int       mismatches = 0;
  bit       stim_done = 1'b0;
  bit       calm = 1'b0;
  longint   cycles = 0;

  function automatic bit node_ok(int t, int e);
    int idx, nidx;
    if (t == goal_t && e == goal_e) return 1'b1;
    if (t >= TILES || e >= NEDGE) return 1'b0;
    idx = t * NEDGE + e;
    if (!lk_flag[idx] || seen[idx]) return 1'b0;
    if (int'(lk_tile[idx]) >= TILES || int'(lk_edge[idx]) >= NEDGE) return 1'b0;
    nidx = int'(lk_tile[idx]) * NEDGE + int'(lk_edge[idx]);
    return int'(lk_tile[nidx]) == t && int'(lk_edge[nidx]) == e;
  endfunction

  function automatic verdict_t walk_graph(request_t r);
    verdict_t v;
    int st_t[$];
    int st_e[$];
    int ht, he, idx, nt, ne;
    v = '0;
    if (r.cmd == CMD_LOAD) begin
      if (int'(r.tile) < TILES && int'(r.edge_req) < NEDGE) begin
        idx = int'(r.tile) * NEDGE + int'(r.edge_req);
        lk_flag[idx] = r.has_link;
        lk_tile[idx] = r.link_tile;
        lk_edge[idx] = r.link_edge;
        lk_written[idx] = 1'b1;
        seen[idx] = 1'b0;
      end
      return v;
    end
    goal_t = int'(r.end_tile);
    goal_e = int'(r.end_edge);
    st_t.push_back(int'(r.tile));
    st_e.push_back(int'(r.edge_req));
    while (st_t.size() > 0) begin
      ht = st_t.pop_back();
      he = st_e.pop_back();
      if (ht == goal_t && he == goal_e) begin
        v.found = 1'b1;
        return v;
      end
      if (ht >= TILES || he >= NEDGE) continue;
      idx = ht * NEDGE + he;
      seen[idx] = 1'b1;
      for (int i = 0; i < NEDGE; i++) begin
        if (node_ok(ht, i)) begin
          if (st_t.size() >= STACK_LIM) begin
            v.overflow = 1'b1;
            return v;
          end
          st_t.push_back(ht);
          st_e.push_back(i);
        end
      end
      nt = int'(lk_tile[idx]);
      ne = int'(lk_edge[idx]);
      if (node_ok(nt, ne)) begin
        if (st_t.size() >= STACK_LIM) begin
          v.overflow = 1'b1;
          return v;
        end
        st_t.push_back(nt);
        st_e.push_back(ne);
      end
    end
    return v;
  endfunction

  // every entry a search may read gets written first, so fill the tiles in use up front
  function automatic request_t load_req(int t, int e, bit l, int lt, int le);
    request_t r;
    r = '0;
    r.cmd = CMD_LOAD;
    r.tile = 8'(t);
    r.edge_req = 3'(e);
    r.has_link = l;
    r.link_tile = 8'(lt);
    r.link_edge = 3'(le);
    r.end_tile = 8'($urandom);
    r.end_edge = 3'($urandom);
    return r;
  endfunction

  function automatic request_t search_req(int t, int e, int et, int ee);
    request_t r;
    r = '0;
    r.cmd = CMD_SEARCH;
    r.tile = 8'(t);
    r.edge_req = 3'(e);
    r.end_tile = 8'(et);
    r.end_edge = 3'(ee);
    r.has_link = 1'($urandom);
    r.link_tile = 8'($urandom);
    r.link_edge = 3'($urandom);
    return r;
  endfunction

  initial begin
    int a, b, ea, eb;
    for (int t = 0; t < USED_TILES; t++)
      for (int e = 0; e < NEDGE; e++)
        pending_q.push_back(load_req(t, e, 1'b0, 0, 0));
    // reciprocal chain through edge 0 and 3 of the tiles in use
    for (int t = 0; t < USED_TILES - 1; t++) begin
      pending_q.push_back(load_req(t, 3, 1'b1, t + 1, 0));
      pending_q.push_back(load_req(t + 1, 0, 1'b1, t, 3));
    end
    pending_q.push_back(load_req(255, 7, 1'b1, 255, 255));
    pending_q.push_back(load_req(9, 6, 1'b1, 0, 0));
    pending_q.push_back(load_req(4, 2, 1'b1, 255, 7));
    pending_q.push_back(load_req(5, 1, 1'b1, 255, 7));
    pending_q.push_back(search_req(0, 0, 5, 0));
    pending_q.push_back(search_req(0, 0, 5, 0));
    pending_q.push_back(search_req(255, 7, 255, 7));
    pending_q.push_back(search_req(255, 7, 0, 0));
    pending_q.push_back(search_req(3, 2, 200, 4));
    pending_q.push_back(search_req(5, 1, 255, 7));
    pending_q.push_back(search_req(4, 2, 0, 0));
    pending_q.push_back(search_req(100, 0, 100, 0));
    for (int n = 0; n < 20; n++) begin
      if ($urandom_range(0, 2) != 0) begin
        a = $urandom_range(0, USED_TILES - 1);
        b = $urandom_range(0, USED_TILES - 1);
        ea = $urandom_range(0, 5);
        eb = $urandom_range(0, 5);
        pending_q.push_back(load_req(a, ea, 1'b1, b, eb));
        pending_q.push_back(load_req(b, eb, $urandom_range(0, 5) != 0, a, ea));
      end else if ($urandom_range(0, 3) == 0) begin
        pending_q.push_back(load_req($urandom, $urandom_range(6, 7), $urandom, $urandom,
                                     $urandom));
      end
      pending_q.push_back(search_req($urandom_range(0, USED_TILES - 1), $urandom_range(0, 6),
                                     $urandom_range(0, USED_TILES - 1), $urandom_range(0, 6)));
    end
    pending_q.push_back(search_req(255, 0, 255, 0));
    pending_q.push_back(search_req(0, 7, 128, 7));
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_init
    initial begin
      seen[g] = 1'b0;
      lk_written[g] = 1'b0;
      lk_flag[g] = 1'b0;
      lk_tile[g] = '0;
      lk_edge[g] = '0;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    {in_ch.cmd, in_ch.tile, in_ch.edge_req, in_ch.has_link, in_ch.link_tile,
     in_ch.link_edge, in_ch.end_tile, in_ch.end_edge} = '0;
    out_ch.ready = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    calm <= (cycles % 3000) < 600;
  end

  // driver
  always @(posedge clk) begin
    request_t r;
    if (rst_n) begin
      if (!in_ch.valid || in_ch.ready) begin
        if (in_ch.valid) begin
          r = pending_q.pop_front();
          verdict_q.push_back(walk_graph(r));
        end
        if (pending_q.size() > 0 && (calm || $urandom_range(0, 99) >= 12)) begin
          r = pending_q[0];
          in_ch.valid <= 1'b1;
          {in_ch.cmd, in_ch.tile, in_ch.edge_req, in_ch.has_link, in_ch.link_tile,
           in_ch.link_edge, in_ch.end_tile, in_ch.end_edge} <= r;
        end else begin
          in_ch.valid <= 1'b0;
          if (pending_q.size() == 0) stim_done <= 1'b1;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (verdict_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result found=%b overflow=%b",
                                         out_ch.found, out_ch.overflow);
        end else begin
          want = verdict_q.pop_front();
          if (want.found !== out_ch.found || want.overflow !== out_ch.overflow) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected found=%b overflow=%b, got found=%b overflow=%b",
                       want.found, want.overflow, out_ch.found, out_ch.overflow);
          end
        end
      end
      out_ch.ready <= calm || $urandom_range(0, 99) >= 12;
    end
  end

  initial begin
    wait (rst_n);
    while (!(stim_done && !in_ch.valid && verdict_q.size() == 0) && cycles < LIMIT)
      @(posedge clk);
    if (cycles >= LIMIT) begin
      $display("edge_graph_dfs_reachability_unit regression: fail");
    end else begin
      repeat (50) @(posedge clk);
      if (mismatches == 0 && verdict_q.size() == 0)
        $display("edge_graph_dfs_reachability_unit regression: pass");
      else
        $display("edge_graph_dfs_reachability_unit regression: fail");
    end
    $finish;
  end
endmodule
